// ----- design/gcd_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and elaboration-time table functions for the
// great-circle distance unit. No dependencies.
package gcd_pkg;

   // Field widths of the channels and configuration port.
   localparam int LAT_W      = 23;
   localparam int LON_W      = 24;
   localparam int DIST_W     = 25;
   localparam int MAG_W      = 24;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 24;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] REG_ORIGIN_LAT = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] REG_ORIGIN_LON = CSR_ADDR_W'(1);

   // Rotation lanes: two half-angle differences and two full latitudes.
   localparam int NUM_LANES = 4;
   localparam int LANE_DLAT = 0;
   localparam int LANE_DLON = 1;
   localparam int LANE_OLAT = 2;
   localparam int LANE_TLAT = 3;

   typedef logic signed [LAT_W-1:0] lat_type;
   typedef logic signed [LON_W-1:0] lon_type;
   typedef logic [MAG_W-1:0]        mag_type;
   typedef logic [DIST_W-1:0]       dist_type;

   localparam lat_type LAT_MAX = 23'sd3240000;
   localparam lat_type LAT_MIN = -23'sd3240000;
   localparam lon_type LON_MAX = 24'sd6480000;
   localparam lon_type LON_MIN = -24'sd6480000;

   // pi in Q61 and radians per tenth of arcsecond in Q81.
   localparam logic [63:0] PI_Q61        = 64'h6487ED5110B4611A;
   localparam logic [63:0] TENTHS_PER_PI = 64'd6480000;
   localparam logic [63:0] RAD_Q81 = ((PI_Q61 / TENTHS_PER_PI) << 20)
      + (((PI_Q61 % TENTHS_PER_PI) << 20) / TENTHS_PER_PI);
   localparam logic [31:0] RAD_HI = RAD_Q81[63:32];
   localparam logic [31:0] RAD_LO = RAD_Q81[31:0];

   // Twice the sphere radius in meters.
   localparam logic [23:0] TWO_RADIUS_M = 24'd12745600;

   // Shift-and-subtract division, used only while building constants.
   function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(2^-i) in Q62 by its power series.
   function automatic logic [63:0] atan_q62(input int i);
      logic signed [63:0] acc;
      logic [63:0]        t;
      int                 e;
      acc = '0;
      if (i == 0) begin
         acc = signed'(PI_Q61 >> 1);
      end else begin
         for (int k = 0; k < 32; k++) begin
            e = i * (2 * k + 1);
            if (e <= 62) begin
               t   = long_div(64'd1 << (62 - e), 64'(2 * k + 1));
               acc = ((k & 1) != 0) ? acc - signed'(t) : acc + signed'(t);
            end
         end
      end
      return acc;
   endfunction

   // atan(2^-i) rounded to f fraction bits.
   function automatic logic [63:0] atan_f(input int i, input int f);
      return (atan_q62(i) + (64'd1 << (61 - f))) >> (62 - f);
   endfunction

   // CORDIC start value: inverse gain of n stages, rounded to f fraction bits.
   function automatic logic [63:0] gain_f(input int n, input int f);
      logic [63:0]  q;
      logic [63:0]  r;
      logic [63:0]  c;
      logic [127:0] sq;
      q = 64'd1 << 62;
      r = '0;
      for (int i = 0; i < n; i++) begin
         if (2 * i <= 62) begin
            q = q - long_div(q, (64'd1 << (2 * i)) + 64'd1);
         end
      end
      for (int b = 63; b >= 0; b--) begin
         c  = r | (64'd1 << b);
         sq = {64'd0, c} * {64'd0, c};
         if (sq <= {q, 64'd0}) begin
            r = c;
         end
      end
      return (r + (64'd1 << (62 - f))) >> (63 - f);
   endfunction

   function automatic logic [63:0] half_pi_f(input int f);
      return (PI_Q61 + (64'd1 << (61 - f))) >> (62 - f);
   endfunction

   function automatic logic [63:0] pi_f(input int f);
      return (PI_Q61 + (64'd1 << (60 - f))) >> (61 - f);
   endfunction

   // Coordinate saturation to the legal ranges.
   function automatic lat_type sat_lat(input lat_type v);
      if (v > LAT_MAX) return LAT_MAX;
      if (v < LAT_MIN) return LAT_MIN;
      return v;
   endfunction

   function automatic lon_type sat_lon(input lon_type v);
      if (v > LON_MAX) return LON_MAX;
      if (v < LON_MIN) return LON_MIN;
      return v;
   endfunction

endpackage

// ----- design/gcd_ifs.sv -----
`timescale 1ns / 1ps
// Channel interfaces of the great-circle distance unit: target requests,
// distance responses and configuration writes. Depends on gcd_pkg.
interface gcd_req_if import gcd_pkg::*; ();
   logic    valid;
   logic    ready;
   lat_type target_lat;
   lon_type target_lon;
   modport source (output valid, output target_lat, output target_lon, input ready);
   modport sink (input valid, input target_lat, input target_lon, output ready);
endinterface

interface gcd_rsp_if import gcd_pkg::*; ();
   logic     valid;
   logic     ready;
   dist_type distance_m;
   modport source (output valid, output distance_m, input ready);
   modport sink (input valid, input distance_m, output ready);
endinterface

interface gcd_csr_if import gcd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output addr, output data, input ready);
   modport sink (input valid, input addr, input data, output ready);
endinterface

// ----- design/gcd_rotate.sv -----
`timescale 1ns / 1ps
// Pipelined rotation-mode CORDIC: sine and cosine of an angle in [0, pi/2],
// one stage per iteration, results saturated to [0, 1]. Depends on gcd_pkg.
module gcd_rotate import gcd_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 30,
   parameter int CORDIC_STAGES   = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [ANGLE_FRAC_BITS:0]   in_angle,
   output logic                       out_valid,
   output logic [ANGLE_FRAC_BITS:0]   out_sin,
   output logic [ANGLE_FRAC_BITS:0]   out_cos
);
   localparam int F = ANGLE_FRAC_BITS;
   localparam int N = CORDIC_STAGES;
   localparam int W = F + 4;
   localparam logic signed [W-1:0] GAIN = signed'(W'(gain_f(N, F)));
   localparam logic signed [W-1:0] ONE  = signed'(W'(1) << F);

   logic signed [W-1:0] x_ff [N];
   logic signed [W-1:0] y_ff [N];
   logic signed [W-1:0] z_ff [N];
   logic                v_ff [N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      localparam logic signed [W-1:0] ATAN = signed'(W'(atan_f(i, F)));
      logic signed [W-1:0] x_p, y_p, z_p;
      logic signed [W-1:0] x_in, y_in, z_in;
      logic                v_p;

      if (i == 0) begin : g_first
         assign x_p = GAIN;
         assign y_p = '0;
         assign z_p = signed'(W'(in_angle));
         assign v_p = in_valid;
      end else begin : g_next
         assign x_p = x_ff[i-1];
         assign y_p = y_ff[i-1];
         assign z_p = z_ff[i-1];
         assign v_p = v_ff[i-1];
      end

      // Turn toward zero residual angle.
      always_comb begin
         if (!z_p[W-1]) begin
            x_in = x_p - (y_p >>> i);
            y_in = y_p + (x_p >>> i);
            z_in = z_p - ATAN;
         end else begin
            x_in = x_p + (y_p >>> i);
            y_in = y_p - (x_p >>> i);
            z_in = z_p + ATAN;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
         end
      end
   end

   // Saturate the last stage to the unit interval.
   always_comb begin
      if (y_ff[N-1][W-1]) begin
         out_sin = '0;
      end else if (y_ff[N-1] > ONE) begin
         out_sin = ONE[F:0];
      end else begin
         out_sin = y_ff[N-1][F:0];
      end
      if (x_ff[N-1][W-1]) begin
         out_cos = '0;
      end else if (x_ff[N-1] > ONE) begin
         out_cos = ONE[F:0];
      end else begin
         out_cos = x_ff[N-1][F:0];
      end
   end

   assign out_valid = v_ff[N-1];

endmodule

// ----- design/gcd_sqrt.sv -----
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage: the root of
// in_value scaled by 2^F, truncated. Depends on gcd_pkg.
module gcd_sqrt import gcd_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 30
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [ANGLE_FRAC_BITS:0] in_value,
   output logic                     out_valid,
   output logic [ANGLE_FRAC_BITS:0] out_root
);
   localparam int F  = ANGLE_FRAC_BITS;
   localparam int NB = F + 1;
   localparam int W2 = 2 * F + 2;

   logic [W2-1:0] op_ff  [NB];
   logic [W2-1:0] res_ff [NB];
   logic          v_ff   [NB];

   for (genvar k = 0; k < NB; k++) begin : g_stage
      localparam logic [W2-1:0] BITV = W2'(1) << (2 * (F - k));
      logic [W2-1:0] op_p, res_p, op_in, res_in, trial;
      logic          v_p;

      if (k == 0) begin : g_first
         assign op_p  = W2'({in_value, {F{1'b0}}});
         assign res_p = '0;
         assign v_p   = in_valid;
      end else begin : g_next
         assign op_p  = op_ff[k-1];
         assign res_p = res_ff[k-1];
         assign v_p   = v_ff[k-1];
      end

      // Try the next root bit against the remainder.
      always_comb begin
         trial = res_p + BITV;
         if (op_p >= trial) begin
            op_in  = op_p - trial;
            res_in = (res_p >> 1) + BITV;
         end else begin
            op_in  = op_p;
            res_in = res_p >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            op_ff[k]  <= op_in;
            res_ff[k] <= res_in;
         end
      end
   end

   assign out_valid = v_ff[NB-1];
   assign out_root  = res_ff[NB-1][F:0];

endmodule

// ----- design/gcd_vector.sv -----
`timescale 1ns / 1ps
// Pipelined vectoring-mode CORDIC: atan2(y, x) for non-negative inputs,
// one stage per iteration, saturated to [0, pi/2]. Depends on gcd_pkg.
module gcd_vector import gcd_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 30,
   parameter int CORDIC_STAGES   = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [ANGLE_FRAC_BITS:0] in_y,
   input  logic [ANGLE_FRAC_BITS:0] in_x,
   output logic                     out_valid,
   output logic [ANGLE_FRAC_BITS:0] out_angle
);
   localparam int F = ANGLE_FRAC_BITS;
   localparam int N = CORDIC_STAGES;
   localparam int W = F + 4;
   localparam logic signed [W-1:0] HALF_PI = signed'(W'(half_pi_f(F)));

   logic signed [W-1:0] x_ff [N];
   logic signed [W-1:0] y_ff [N];
   logic signed [W-1:0] z_ff [N];
   logic                v_ff [N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      localparam logic signed [W-1:0] ATAN = signed'(W'(atan_f(i, F)));
      logic signed [W-1:0] x_p, y_p, z_p;
      logic signed [W-1:0] x_in, y_in, z_in;
      logic                v_p;

      if (i == 0) begin : g_first
         assign x_p = signed'(W'(in_x));
         assign y_p = signed'(W'(in_y));
         assign z_p = '0;
         assign v_p = in_valid;
      end else begin : g_next
         assign x_p = x_ff[i-1];
         assign y_p = y_ff[i-1];
         assign z_p = z_ff[i-1];
         assign v_p = v_ff[i-1];
      end

      // Drive y toward zero and accumulate the angle turned.
      always_comb begin
         if (y_p > 0) begin
            x_in = x_p + (y_p >>> i);
            y_in = y_p - (x_p >>> i);
            z_in = z_p + ATAN;
         end else begin
            x_in = x_p - (y_p >>> i);
            y_in = y_p + (x_p >>> i);
            z_in = z_p - ATAN;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
         end
      end
   end

   // Saturate the angle to the first quadrant.
   always_comb begin
      if (z_ff[N-1][W-1]) begin
         out_angle = '0;
      end else if (z_ff[N-1] > HALF_PI) begin
         out_angle = HALF_PI[F:0];
      end else begin
         out_angle = z_ff[N-1][F:0];
      end
   end

   assign out_valid = v_ff[N-1];

endmodule

// ----- design/great_circle_distance_top.sv -----
`timescale 1ns / 1ps
// Top level of the haversine great-circle distance unit.
// Depends on gcd_pkg, gcd_ifs, gcd_rotate, gcd_sqrt and gcd_vector.
//
// Usage:
//   The csr channel sets the reference point (origin_lat at index 0,
//   origin_lon at index 1, tenths of arcsecond); it is always ready and
//   should be written while no request is in flight. Each req transfer
//   carries a target point; each rsp transfer returns its distance in
//   whole meters, in request order, one response per request.
//   The pipeline holds three angle-conversion stages, a rotation CORDIC
//   per angle, four product stages, a square root with one stage per
//   result bit, a vectoring CORDIC and two scaling stages.
//   Throughput is one transfer per cycle unless the output stalls. All stages advance together
//   whenever the output register is empty or being drained, so req.ready
//   drops only while a response is held by the receiver; nothing is lost
//   or repeated during a stall.
//   Synchronous reset empties the pipeline and sets the origin to 0, 0.
module great_circle_distance_top import gcd_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 30,
   parameter int CORDIC_STAGES   = 24
) (
   input  logic     clock,
   input  logic     reset,
   gcd_req_if.sink  req_ch,
   gcd_rsp_if.source rsp_ch,
   gcd_csr_if.sink  csr_ch
);
   localparam int F     = ANGLE_FRAC_BITS;
   localparam int N     = CORDIC_STAGES;
   localparam int SUM_W = 88;
   localparam int PW    = 2 * F + 2;
   localparam int DW    = F + 24 + 1;
   localparam logic [F:0]   ONE     = {1'b1, {F{1'b0}}};
   localparam logic [F+2:0] HALF_PI = (F+3)'(half_pi_f(F));
   localparam logic [F+2:0] PI_A    = (F+3)'(pi_f(F));
   localparam logic [PW:0]  P_RND   = (PW+1)'(1) << (F - 1);
   localparam logic [DW:0]  D_RND   = (DW+1)'(1) << (F - 1);
   localparam logic [DW-F:0] D_MAX  = (DW-F+1)'({DIST_W{1'b1}});

   // Configuration registers.
   lat_type origin_lat_ff;
   lon_type origin_lon_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_lat_ff <= '0;
         origin_lon_ff <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.addr)
            REG_ORIGIN_LAT: origin_lat_ff <= lat_type'(csr_ch.data[LAT_W-1:0]);
            REG_ORIGIN_LON: origin_lon_ff <= lon_type'(csr_ch.data[LON_W-1:0]);
            default: ;
         endcase
      end
   end

   // Global advance: the whole pipeline moves when the output can take data.
   logic     adv;
   logic     rsp_valid_ff;
   dist_type dist_ff;

   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // Stage 1: saturate coordinates, form differences and magnitudes.
   lat_type                 t_lat, o_lat;
   lon_type                 t_lon, o_lon;
   logic signed [LAT_W:0]   d_lat;
   logic signed [LON_W:0]   d_lon;
   mag_type                 mag_in [NUM_LANES];
   mag_type                 mag_ff [NUM_LANES];
   logic                    v1_ff;

   always_comb begin
      t_lat = sat_lat(req_ch.target_lat);
      t_lon = sat_lon(req_ch.target_lon);
      o_lat = sat_lat(origin_lat_ff);
      o_lon = sat_lon(origin_lon_ff);
      d_lat = (LAT_W+1)'(t_lat) - (LAT_W+1)'(o_lat);
      d_lon = (LON_W+1)'(t_lon) - (LON_W+1)'(o_lon);
      mag_in[LANE_DLAT] = MAG_W'(d_lat[LAT_W] ? -d_lat : d_lat);
      mag_in[LANE_DLON] = MAG_W'(d_lon[LON_W] ? -d_lon : d_lon);
      mag_in[LANE_OLAT] = MAG_W'(o_lat[LAT_W-1] ? -o_lat : o_lat);
      mag_in[LANE_TLAT] = MAG_W'(t_lat[LAT_W-1] ? -t_lat : t_lat);
   end

   // Stage 2: partial products of magnitude times radians per tenth.
   logic [55:0]  phi_ff [NUM_LANES];
   logic [55:0]  plo_ff [NUM_LANES];
   logic [F:0]   ang_ff [NUM_LANES];
   logic         v2_ff, v3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff <= mag_in;
         for (int l = 0; l < NUM_LANES; l++) begin
            phi_ff[l] <= 56'(mag_ff[l]) * 56'(RAD_HI);
            plo_ff[l] <= 56'(mag_ff[l]) * 56'(RAD_LO);
         end
      end
   end

   // Stage 3: round to F fraction bits and fold into [0, pi/2].
   for (genvar l = 0; l < NUM_LANES; l++) begin : g_angle
      localparam bit HALF = (l == LANE_DLAT) || (l == LANE_DLON);
      localparam int SH   = HALF ? 82 - F : 81 - F;
      logic [SUM_W-1:0] sum;
      logic [F+2:0]     a_raw;
      logic [F+2:0]     a_sat;
      logic [F:0]       ang_in;

      always_comb begin
         sum   = {phi_ff[l], 32'd0} + SUM_W'(plo_ff[l]) + (SUM_W'(1) << (SH - 1));
         a_raw = sum[SH +: F+3];
         a_sat = a_raw;
         if (HALF) begin
            // The sine is squared, so pi minus the angle serves as well.
            if (a_sat > PI_A) begin
               a_sat = PI_A;
            end
            if (a_sat > HALF_PI) begin
               a_sat = PI_A - a_sat;
            end
         end else if (a_sat > HALF_PI) begin
            a_sat = HALF_PI;
         end
         ang_in = a_sat[F:0];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ang_ff[l] <= ang_in;
         end
      end
   end

   // Sine and cosine of each angle.
   logic [F:0]           sin_w [NUM_LANES];
   logic [F:0]           cos_w [NUM_LANES];
   logic [NUM_LANES-1:0] rot_v;

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_rot
      gcd_rotate #(
         .ANGLE_FRAC_BITS (F),
         .CORDIC_STAGES   (N)
      ) u_rot (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (v3_ff),
         .in_angle  (ang_ff[l]),
         .out_valid (rot_v[l]),
         .out_sin   (sin_w[l]),
         .out_cos   (cos_w[l])
      );
   end

   // Stages 4 to 7: squares, cosine product, haversine sum.
   logic [PW-1:0] p_lat_ff, p_lon_ff, p_cc_ff, p_h_ff;
   logic [F:0]    q_lat_ff, q_lon_ff, q_cc_ff, q_lat6_ff;
   logic [F:0]    h_ff, hc_ff;
   logic [PW:0]   r_lat, r_lon, r_cc, r_h;
   logic [F+1:0]  h_sum;
   logic [F:0]    h_in;
   logic          v4_ff, v5_ff, v6_ff, v7_ff;

   always_comb begin
      r_lat = (PW+1)'(p_lat_ff) + P_RND;
      r_lon = (PW+1)'(p_lon_ff) + P_RND;
      r_cc  = (PW+1)'(p_cc_ff) + P_RND;
      r_h   = (PW+1)'(p_h_ff) + P_RND;
      h_sum = (F+2)'(q_lat6_ff) + (F+2)'(r_h[F +: F+1]);
      h_in  = (h_sum > (F+2)'(ONE)) ? ONE : h_sum[F:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_lat_ff  <= PW'(sin_w[LANE_DLAT]) * PW'(sin_w[LANE_DLAT]);
         p_lon_ff  <= PW'(sin_w[LANE_DLON]) * PW'(sin_w[LANE_DLON]);
         p_cc_ff   <= PW'(cos_w[LANE_OLAT]) * PW'(cos_w[LANE_TLAT]);
         q_lat_ff  <= r_lat[F +: F+1];
         q_lon_ff  <= r_lon[F +: F+1];
         q_cc_ff   <= r_cc[F +: F+1];
         p_h_ff    <= PW'(q_lon_ff) * PW'(q_cc_ff);
         q_lat6_ff <= q_lat_ff;
         h_ff      <= h_in;
         hc_ff     <= ONE - h_in;
      end
   end

   // Square roots of h and 1 - h.
   logic [F:0] root_y, root_x;
   logic       sq_vy, sq_vx;

   gcd_sqrt #(.ANGLE_FRAC_BITS (F)) u_sqrt_y (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v7_ff),
      .in_value  (h_ff),
      .out_valid (sq_vy),
      .out_root  (root_y)
   );

   gcd_sqrt #(.ANGLE_FRAC_BITS (F)) u_sqrt_x (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v7_ff),
      .in_value  (hc_ff),
      .out_valid (sq_vx),
      .out_root  (root_x)
   );

   // Central half angle.
   logic [F:0] theta;
   logic       vec_v;

   gcd_vector #(
      .ANGLE_FRAC_BITS (F),
      .CORDIC_STAGES   (N)
   ) u_vec (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sq_vy && sq_vx),
      .in_y      (root_y),
      .in_x      (root_x),
      .out_valid (vec_v),
      .out_angle (theta)
   );

   // Stages 8 and 9: scale by the diameter, round and saturate.
   logic [DW-1:0] pd_ff;
   logic [DW:0]   d_rnd;
   logic [DW-F:0] d_full;
   dist_type      dist_in;
   logic          v8_ff;

   always_comb begin
      d_rnd   = (DW+1)'(pd_ff) + D_RND;
      d_full  = d_rnd[F +: DW-F+1];
      dist_in = (d_full > D_MAX) ? {DIST_W{1'b1}} : d_full[DIST_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pd_ff   <= DW'(theta) * DW'(TWO_RADIUS_M);
         dist_ff <= dist_in;
      end
   end

   // Valid bits that travel with the front, product and output stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_ch.valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= &rot_v;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         v8_ff        <= vec_v;
         rsp_valid_ff <= v8_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.distance_m = dist_ff;

   // A valid response is never farther than half the circumference.
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (dist_ff <= dist_type'(20021000)))
      else $error("distance beyond half circumference");

   // The haversine value and its complement always add up to one.
   a_h_sum: assert property (@(posedge clock) disable iff (reset)
      v7_ff |-> ((F+2)'(h_ff) + (F+2)'(hc_ff) == (F+2)'(ONE)))
      else $error("haversine complement mismatch");

   // All rotation lanes move in lock step.
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (rot_v == '0) || (rot_v == '1))
      else $error("rotation lanes out of step");

   // A stalled pipeline holds its converted half-angle differences.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !adv) |=> $stable(ang_ff[LANE_DLAT]) && $stable(ang_ff[LANE_DLON]))
      else $error("angle stage changed during a stall");

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("response pending after reset");

endmodule
